### rtl/core/dirty_region_planner_macros.svh
// Assertion macros of the dirty region planner RTL
`ifndef DIRTY_REGION_PLANNER_MACROS_SVH
`define DIRTY_REGION_PLANNER_MACROS_SVH

// same-cycle implication
`define DRP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DRP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/drp_pkg.sv
// Types and constants of the dirty region planner
`default_nettype none
package drp_pkg;

   localparam int CoordBits    = 16;
   localparam int RegBits      = 16;
   localparam int EdgeBits     = ((CoordBits > RegBits) ? CoordBits : RegBits) + 1;
   localparam int LaneCount    = 2;
   localparam int CsrIndexBits = 2;

   typedef logic [CoordBits-1:0]    coord_type;
   typedef logic [RegBits-1:0]      reg_type;
   typedef logic [EdgeBits-1:0]     edge_type;
   typedef logic [CsrIndexBits-1:0] csr_addr_type;

   typedef enum logic [CsrIndexBits-1:0] {
      CSR_PAD    = 2'd0,
      CSR_WIDTH  = 2'd1,
      CSR_HEIGHT = 2'd2
   } csr_index_type;

   typedef struct packed {
      reg_type pad;
      reg_type width;
      reg_type height;
   } cfg_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type w;
      coord_type h;
   } rect_type;

   typedef struct packed {
      logic     valid;
      edge_type l;
      edge_type t;
      edge_type r;
      edge_type b;
   } box_type;

   typedef struct packed {
      logic adv_clip;
      logic adv_grow;
      logic adv_out;
   } stage_ctl_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type w;
      coord_type h;
      logic      empty;
   } result_type;

endpackage
`default_nettype wire

### rtl/core/drp_ifs.sv
// Channel interfaces of the dirty region planner
`default_nettype none
interface drp_req_if;
   logic               valid;
   logic               ready;
   drp_pkg::coord_type cur_x;
   drp_pkg::coord_type cur_y;
   drp_pkg::coord_type cur_w;
   drp_pkg::coord_type cur_h;
   drp_pkg::coord_type prev_x;
   drp_pkg::coord_type prev_y;
   drp_pkg::coord_type prev_w;
   drp_pkg::coord_type prev_h;

   modport source (output valid, cur_x, cur_y, cur_w, cur_h,
                   prev_x, prev_y, prev_w, prev_h, input ready);
   modport sink   (input valid, cur_x, cur_y, cur_w, cur_h,
                   prev_x, prev_y, prev_w, prev_h, output ready);
endinterface

interface drp_rsp_if;
   logic               valid;
   logic               ready;
   drp_pkg::coord_type dirty_x;
   drp_pkg::coord_type dirty_y;
   drp_pkg::coord_type dirty_w;
   drp_pkg::coord_type dirty_h;
   logic               dirty_empty;

   modport source (output valid, dirty_x, dirty_y, dirty_w, dirty_h, dirty_empty,
                   input ready);
   modport sink   (input valid, dirty_x, dirty_y, dirty_w, dirty_h, dirty_empty,
                   output ready);
endinterface

interface drp_csr_if;
   logic                  valid;
   logic                  ready;
   drp_pkg::csr_addr_type index;
   drp_pkg::reg_type      data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/core/drp_lane.sv
// One rectangle lane: clip to the display, then pad and clip again
`default_nettype none
module drp_lane (
   input  logic                   clock,
   input  drp_pkg::stage_ctl_type ctl,
   input  drp_pkg::cfg_type       cfg,
   input  drp_pkg::rect_type      rect,
   output drp_pkg::box_type       box
);
   import drp_pkg::*;

   edge_type sw_e;
   edge_type sh_e;
   edge_type pad_e;
   edge_type x_e;
   edge_type y_e;
   edge_type xr_e;
   edge_type yb_e;
   edge_type r_sum;
   edge_type b_sum;
   box_type  clip_in;
   box_type  clip_ff;
   box_type  grow_in;
   box_type  grow_ff;

   assign sw_e  = EdgeBits'(cfg.width);
   assign sh_e  = EdgeBits'(cfg.height);
   assign pad_e = EdgeBits'(cfg.pad);
   assign x_e   = EdgeBits'(rect.x);
   assign y_e   = EdgeBits'(rect.y);
   assign xr_e  = x_e + EdgeBits'(rect.w);
   assign yb_e  = y_e + EdgeBits'(rect.h);

   always_comb begin
      clip_in.l     = (x_e  < sw_e) ? x_e  : sw_e;
      clip_in.t     = (y_e  < sh_e) ? y_e  : sh_e;
      clip_in.r     = (xr_e < sw_e) ? xr_e : sw_e;
      clip_in.b     = (yb_e < sh_e) ? yb_e : sh_e;
      clip_in.valid = (cfg.width != '0) && (cfg.height != '0) &&
                      (rect.w != '0) && (rect.h != '0) &&
                      (clip_in.r > clip_in.l) && (clip_in.b > clip_in.t);
   end

   always_ff @(posedge clock) begin
      if (ctl.adv_clip) begin
         clip_ff <= clip_in;
      end
   end

   assign r_sum = clip_ff.r + pad_e;
   assign b_sum = clip_ff.b + pad_e;

   always_comb begin
      grow_in.l     = (clip_ff.l > pad_e) ? (clip_ff.l - pad_e) : '0;
      grow_in.t     = (clip_ff.t > pad_e) ? (clip_ff.t - pad_e) : '0;
      grow_in.r     = (r_sum < sw_e) ? r_sum : sw_e;
      grow_in.b     = (b_sum < sh_e) ? b_sum : sh_e;
      grow_in.valid = clip_ff.valid &&
                      (grow_in.r > grow_in.l) && (grow_in.b > grow_in.t);
   end

   always_ff @(posedge clock) begin
      if (ctl.adv_grow) begin
         grow_ff <= grow_in;
      end
   end

   assign box = grow_ff;

endmodule
`default_nettype wire

### rtl/core/drp_merge.sv
// Bounding union of the lane boxes into the output register
`default_nettype none
module drp_merge (
   input  logic                   clock,
   input  drp_pkg::stage_ctl_type ctl,
   input  drp_pkg::box_type       boxes [drp_pkg::LaneCount],
   output drp_pkg::result_type    result
);
   import drp_pkg::*;

   box_type    acc;
   result_type result_in;
   result_type result_ff;

   always_comb begin
      acc = '0;
      for (int i = 0; i < LaneCount; i++) begin
         if (boxes[i].valid) begin
            if (!acc.valid) begin
               acc = boxes[i];
            end else begin
               acc.l = (boxes[i].l < acc.l) ? boxes[i].l : acc.l;
               acc.t = (boxes[i].t < acc.t) ? boxes[i].t : acc.t;
               acc.r = (boxes[i].r > acc.r) ? boxes[i].r : acc.r;
               acc.b = (boxes[i].b > acc.b) ? boxes[i].b : acc.b;
            end
         end
      end
   end

   always_comb begin
      result_in = '0;
      if (acc.valid) begin
         result_in.x = CoordBits'(acc.l);
         result_in.y = CoordBits'(acc.t);
         result_in.w = CoordBits'(acc.r - acc.l);
         result_in.h = CoordBits'(acc.b - acc.t);
      end else begin
         result_in.empty = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.adv_out) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule
`default_nettype wire

### rtl/core/dirty_region_planner.sv
// Top level of the dirty region planner
//
//   channel   dir   beat contents
//   req_bus   in    current and previous rectangle (x, y, w, h each)
//   rsp_bus   out   dirty_x, dirty_y, dirty_w, dirty_h, dirty_empty
//   csr_bus   in    register index and write data, always ready
//
// Three-stage pipeline: clip, pad, union. One beat per cycle while rsp_bus is not stalled.
// Each stage loads when empty or when the stage after it moves on.
// Reset clears the stage valids and the registers (pad, width, height) to zero.
// A stalled rsp_bus backs up through the stages to req_bus.ready.
`default_nettype none
`include "dirty_region_planner_macros.svh"
module dirty_region_planner (
   input  logic         clock,
   input  logic         reset,
   drp_req_if.sink      req_bus,
   drp_rsp_if.source    rsp_bus,
   drp_csr_if.sink      csr_bus
);
   import drp_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   logic          s1_v_ff;
   logic          s1_v_in;
   logic          s2_v_ff;
   logic          s2_v_in;
   logic          s3_v_ff;
   logic          s3_v_in;
   logic          out_ready;
   logic          s2_ready;
   logic          s1_ready;
   stage_ctl_type ctl;
   rect_type      rects [LaneCount];
   box_type       boxes [LaneCount];
   result_type    result;
   edge_type      span_x;
   edge_type      span_y;

   // config registers
   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_PAD:    cfg_in.pad    = csr_bus.data;
            CSR_WIDTH:  cfg_in.width  = csr_bus.data;
            CSR_HEIGHT: cfg_in.height = csr_bus.data;
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   // stage control
   assign out_ready     = !s3_v_ff || rsp_bus.ready;
   assign s2_ready      = !s2_v_ff || out_ready;
   assign s1_ready      = !s1_v_ff || s2_ready;
   assign req_bus.ready = s1_ready;

   assign ctl.adv_clip = s1_ready;
   assign ctl.adv_grow = s2_ready;
   assign ctl.adv_out  = out_ready;

   assign s1_v_in = s1_ready  ? req_bus.valid : s1_v_ff;
   assign s2_v_in = s2_ready  ? s1_v_ff       : s2_v_ff;
   assign s3_v_in = out_ready ? s2_v_ff       : s3_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff  <= '0;
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         cfg_ff  <= cfg_in;
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
         s3_v_ff <= s3_v_in;
      end
   end

   // lanes
   assign rects[0] = '{x: req_bus.cur_x,  y: req_bus.cur_y,
                       w: req_bus.cur_w,  h: req_bus.cur_h};
   assign rects[1] = '{x: req_bus.prev_x, y: req_bus.prev_y,
                       w: req_bus.prev_w, h: req_bus.prev_h};

   for (genvar i = 0; i < LaneCount; i++) begin : g_lane
      drp_lane u_lane (
         .clock (clock),
         .ctl   (ctl),
         .cfg   (cfg_ff),
         .rect  (rects[i]),
         .box   (boxes[i])
      );
   end

   drp_merge u_merge (
      .clock  (clock),
      .ctl    (ctl),
      .boxes  (boxes),
      .result (result)
   );

   assign rsp_bus.valid       = s3_v_ff;
   assign rsp_bus.dirty_x     = result.x;
   assign rsp_bus.dirty_y     = result.y;
   assign rsp_bus.dirty_w     = result.w;
   assign rsp_bus.dirty_h     = result.h;
   assign rsp_bus.dirty_empty = result.empty;

   // checks
   assign span_x = EdgeBits'(result.x) + EdgeBits'(result.w);
   assign span_y = EdgeBits'(result.y) + EdgeBits'(result.h);

   `DRP_ASSERT_NOW(a_empty_zero, clock, reset, s3_v_ff && result.empty,
      (result.x == '0) && (result.y == '0) && (result.w == '0) && (result.h == '0),
      "empty beat carries nonzero region")
   `DRP_ASSERT_NOW(a_region_on_screen, clock, reset, s3_v_ff && !result.empty,
      (result.w != '0) && (result.h != '0) &&
      (span_x <= EdgeBits'(cfg_ff.width)) && (span_y <= EdgeBits'(cfg_ff.height)),
      "region degenerate or off the display")
   `DRP_ASSERT_NEXT(a_accept_loads, clock, reset, req_bus.valid && req_bus.ready,
      s1_v_ff, "accepted beat lost at clip stage")
   `DRP_ASSERT_NEXT(a_grow_holds, clock, reset, s2_v_ff && !out_ready,
      s2_v_ff && s3_v_ff, "stalled pad stage dropped its beat")

endmodule
`default_nettype wire
